// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define RHRB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define RHRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RHRB_ASSERT(label, clk, rst, prop)
`define RHRB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/rhrb_pkg.sv =====
// Shared constants, codes and interface structs of the rewind history buffer.
// Depends on nothing.
package rhrb_pkg;

  localparam int DEPTH   = 128;                 // ring depth, power of two
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int NUM_WORDS = 8;
  localparam int SNAP_W  = WORD_W * NUM_WORDS;
  localparam int POS_W   = WORD_W * 3;          // position words sit in the low bits
  localparam int ACT_W   = 2;

  localparam logic [ACT_W-1:0] ACT_RECORD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FULL    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PARTIAL = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [ACT_W-1:0] action;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] offset;
  } status_t;

endpackage

// ===== design/rhrb_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
module rhrb_ram #(
  parameter int WIDTH  = 256,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/rhrb_ctrl.sv =====
// Ring control: write pointer, fill count, playback offset and the request sequencer.
// Depends on rhrb_pkg.
module rhrb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               held,
  output rhrb_pkg::mem_req_t mem_req,
  output rhrb_pkg::rsp_t     rsp,
  input  logic               rsp_ready,
  output rhrb_pkg::status_t  status
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic                           state, state_next;
  logic [rhrb_pkg::ADDR_W-1:0]    wp, wp_next;
  logic [rhrb_pkg::CNT_W-1:0]     fill, fill_next;
  logic [rhrb_pkg::CNT_W-1:0]     offset, offset_next;
  logic [rhrb_pkg::ACT_W-1:0]     action, action_next;
  logic [rhrb_pkg::CNT_W-1:0]     offset_up;
  logic [rhrb_pkg::CNT_W-1:0]     offset_down;
  logic                           accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign offset_up   = offset + rhrb_pkg::CNT_W'(fill > offset);
  assign offset_down = offset - rhrb_pkg::CNT_W'(1);

  always_comb begin
    state_next      = state;
    wp_next         = wp;
    fill_next       = fill;
    offset_next     = offset;
    action_next     = action;
    mem_req         = '0;
    mem_req.wr_addr = wp;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RESP;
          if (held && (fill != '0)) begin
            // Step back; full depth wraps onto the oldest entry.
            offset_next     = offset_up;
            action_next     = rhrb_pkg::ACT_FULL;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = wp - offset_up[rhrb_pkg::ADDR_W-1:0];
          end else if ((offset != '0) && (offset_down != '0)) begin
            offset_next     = offset_down;
            action_next     = rhrb_pkg::ACT_PARTIAL;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = wp - offset_down[rhrb_pkg::ADDR_W-1:0];
          end else begin
            offset_next   = '0;
            action_next   = rhrb_pkg::ACT_RECORD;
            mem_req.wr_en = 1'b1;
            wp_next       = wp + rhrb_pkg::ADDR_W'(1);
            fill_next     = fill +
                            rhrb_pkg::CNT_W'(fill != rhrb_pkg::CNT_W'(rhrb_pkg::DEPTH));
          end
        end
      end
      S_RESP: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wp     <= '0;
      fill   <= '0;
      offset <= '0;
    end else begin
      state  <= state_next;
      wp     <= wp_next;
      fill   <= fill_next;
      offset <= offset_next;
    end
  end

  always_ff @(posedge clk) begin
    action <= action_next;
  end

  assign rsp.valid     = (state == S_RESP);
  assign rsp.action    = action;
  assign status.fill   = fill;
  assign status.offset = offset;

endmodule

// ===== design/rewind_history_ring_buffer_top.sv =====
// Rewind history ring buffer: top level with the snapshot RAM and output register.
// Depends on rhrb_pkg, rhrb_ram, rhrb_ctrl and assert_macros.svh.
//
// One request per frame: tuser carries the rewind-held flag, tdata the snapshot.
// For each request the accept cycle updates the pointers and issues the snapshot
// RAM access; in the response state the result, from the RAM's registered read
// data, moves into the output register when that is free. The next request is
// taken as soon as that result is in the output register, even while it still
// waits there. The RAM needs no clearing after reset: entries are read only
// after they are written. Action codes on m_axis_tuser: 0 recorded, 1 full
// restore, 2 rotation and velocity restore; data words not restored read as zero.
`include "assert_macros.svh"

module rewind_history_ring_buffer_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, rot_x, rot_y, vel_x, vel_y, vel_z (32 bits each)
  input  logic [255:0] s_axis_tdata,
  // rewind_held
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y,
  // out_vel_x, out_vel_y, out_vel_z (32 bits each)
  output logic [255:0] m_axis_tdata,
  // action
  output logic [1:0]   m_axis_tuser
);

  rhrb_pkg::mem_req_t           mem_req;
  rhrb_pkg::rsp_t               rsp;
  rhrb_pkg::status_t            status;
  logic                         rsp_ready;
  logic [rhrb_pkg::SNAP_W-1:0]  rd_data;
  logic [rhrb_pkg::SNAP_W-1:0]  rsp_data;

  rhrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .held      (s_axis_tuser[0]),
    .mem_req   (mem_req),
    .rsp       (rsp),
    .rsp_ready (rsp_ready),
    .status    (status)
  );

  rhrb_ram #(
    .WIDTH  (rhrb_pkg::SNAP_W),
    .ADDR_W (rhrb_pkg::ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (s_axis_tdata),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // Load the output register whenever it is empty or being drained.
  assign rsp_ready = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    case (rsp.action)
      rhrb_pkg::ACT_FULL:    rsp_data = rd_data;
      rhrb_pkg::ACT_PARTIAL: rsp_data = {rd_data[rhrb_pkg::SNAP_W-1:rhrb_pkg::POS_W],
                                         {rhrb_pkg::POS_W{1'b0}}};
      default:               rsp_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rsp_ready) begin
      m_axis_tvalid <= rsp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid && rsp_ready) begin
      m_axis_tdata <= rsp_data;
      m_axis_tuser <= rsp.action;
    end
  end

  `RHRB_ASSERT(a_offset_le_fill, clk, rst, status.offset <= status.fill)
  `RHRB_ASSERT(a_fill_le_depth, clk, rst,
    status.fill <= rhrb_pkg::CNT_W'(rhrb_pkg::DEPTH))
  `RHRB_ASSERT_NEXT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready,
    !s_axis_tready && rsp.valid)
  `RHRB_ASSERT(a_record_zero, clk, rst,
    !(m_axis_tvalid && (m_axis_tuser == rhrb_pkg::ACT_RECORD)) || (m_axis_tdata == '0))
  `RHRB_ASSERT(a_partial_no_pos, clk, rst,
    !(m_axis_tvalid && (m_axis_tuser == rhrb_pkg::ACT_PARTIAL)) ||
    (m_axis_tdata[rhrb_pkg::POS_W-1:0] == '0))

endmodule
